// ----- src/hrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, phase codes and method name tables for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int NUM_METHODS     = 8;

  localparam logic [3:0] PH_METHOD = 4'd0;
  localparam logic [3:0] PH_SKIP1  = 4'd1;
  localparam logic [3:0] PH_URL    = 4'd2;
  localparam logic [3:0] PH_SKIP2  = 4'd3;
  localparam logic [3:0] PH_T1     = 4'd4;
  localparam logic [3:0] PH_T2     = 4'd5;
  localparam logic [3:0] PH_P      = 4'd6;
  localparam logic [3:0] PH_SLASH  = 4'd7;
  localparam logic [3:0] PH_MAJOR  = 4'd8;
  localparam logic [3:0] PH_DOT    = 4'd9;
  localparam logic [3:0] PH_MINOR  = 4'd10;
  localparam logic [3:0] PH_DONE   = 4'd11;
  localparam logic [3:0] PH_FAIL   = 4'd12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // names right-justified: first character in the highest occupied byte
  localparam logic [63:0] NAME_TAB [NUM_METHODS] = '{
    64'("GET"), 64'("POST"), 64'("OPTIONS"), 64'("PUT"),
    64'("DELETE"), 64'("CONNECT"), 64'("HEAD"), 64'("TRACE")
  };
  localparam logic [3:0] NAME_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd7, 4'd3, 4'd6, 4'd7, 4'd4, 4'd5
  };

  typedef struct packed {
    logic       has_url;
    logic       has_sum;
    logic [7:0] url_byte;
    logic [2:0] method;
    logic [3:0] major;
    logic [3:0] minor;
    logic       ok;
  } cmd_t;

  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
    int sh;
    logic [63:0] w;
    sh = 0;
    w  = NAME_TAB[idx] >> 0;
    if ({1'b0, pos} >= NAME_LEN[idx]) begin
      return 8'h00;
    end
    sh = (int'(NAME_LEN[idx]) - 1 - int'(pos)) * 8;
    w  = NAME_TAB[idx] >> sh;
    return w[7:0];
  endfunction

endpackage

// ----- src/hrlp_front.sv -----
// ----------------------------------------------------------------------------
// hrlp_front
// Accepts line bytes, tracks the parse phase and issues result commands.
// ----------------------------------------------------------------------------
module hrlp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_line_byte,
  input  logic          in_end_of_line,
  input  logic          q_full,
  output logic          q_push,
  output hrlp_pkg::cmd_t q_data
);
  import hrlp_pkg::*;

  logic [3:0] phase_r, phase_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] cand_r, cand_nxt;
  logic [3:0] major_r, major_nxt;
  logic [3:0] minor_r, minor_nxt;
  logic       vok_r, vok_nxt;
  logic       accept;
  logic       emit_url;
  logic [7:0] keep;
  logic [3:0] dig;
  logic [2:0] meth;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    dig = 4'd0;
    if (in_line_byte inside {[8'h30:8'h39]}) begin
      dig = 4'(in_line_byte - CH_ZERO);
    end
  end

  always_comb begin
    keep = '0;
    for (int i = 0; i < NUM_METHODS; i++) begin
      keep[i] = (pos_r < NAME_LEN[i]) && (name_char(3'(i), pos_r[2:0]) == in_line_byte);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cand_nxt  = cand_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    vok_nxt   = vok_r;
    emit_url  = 1'b0;
    case (phase_r)
      PH_METHOD: begin
        if (in_line_byte == CH_SPACE) begin
          phase_nxt = PH_SKIP1;
        end else begin
          if (pos_r < 4'd8) begin
            pos_nxt = pos_r + 4'd1;
          end
          cand_nxt = cand_r & keep;
        end
      end
      PH_SKIP1, PH_URL: begin
        if (in_line_byte == CH_SPACE) begin
          if (phase_r == PH_URL) begin
            phase_nxt = PH_SKIP2;
          end
        end else begin
          phase_nxt = PH_URL;
          emit_url  = 1'b1;
        end
      end
      PH_SKIP2: begin
        if (in_line_byte != CH_SPACE) begin
          phase_nxt = (in_line_byte == CH_H) ? PH_T1 : PH_FAIL;
        end
      end
      PH_T1:    phase_nxt = (in_line_byte == CH_T) ? PH_T2 : PH_FAIL;
      PH_T2:    phase_nxt = (in_line_byte == CH_T) ? PH_P : PH_FAIL;
      PH_P:     phase_nxt = (in_line_byte == CH_P) ? PH_SLASH : PH_FAIL;
      PH_SLASH: phase_nxt = (in_line_byte == CH_SLASH) ? PH_MAJOR : PH_FAIL;
      PH_MAJOR: begin
        major_nxt = dig;
        phase_nxt = PH_DOT;
      end
      PH_DOT: begin
        if (in_line_byte == CH_DOT) begin
          vok_nxt   = 1'b1;
          phase_nxt = PH_MINOR;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_MINOR: begin
        minor_nxt = dig;
        phase_nxt = PH_DONE;
      end
      default: ;
    endcase
  end

  // lowest matching candidate wins
  always_comb begin
    meth = 3'd0;
    for (int i = NUM_METHODS - 1; i >= 0; i--) begin
      if (cand_nxt[i] && (NAME_LEN[i] == pos_nxt)) begin
        meth = 3'(i);
      end
    end
  end

  always_comb begin
    q_data.has_url  = emit_url;
    q_data.has_sum  = in_end_of_line;
    q_data.url_byte = in_line_byte;
    q_data.method   = meth;
    q_data.major    = major_nxt;
    q_data.minor    = vok_nxt ? minor_nxt : 4'd0;
    q_data.ok       = vok_nxt;
  end

  assign q_push = accept && (emit_url || in_end_of_line);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end_of_line)) begin
      phase_r <= PH_METHOD;
      pos_r   <= 4'd0;
      cand_r  <= 8'hff;
      major_r <= 4'd0;
      minor_r <= 4'd0;
      vok_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      vok_r   <= vok_nxt;
    end
  end

endmodule

// ----- src/hrlp_queue.sv -----
// ----------------------------------------------------------------------------
// hrlp_queue
// Short command queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
module hrlp_queue #(
  parameter int DEPTH = hrlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hrlp_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output hrlp_pkg::cmd_t head
);
  import hrlp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("command popped from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count lost a push");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- src/hrlp_back.sv -----
// ----------------------------------------------------------------------------
// hrlp_back
// Expands queued commands into URL byte and line summary result transactions.
// ----------------------------------------------------------------------------
module hrlp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  hrlp_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic           out_kind,
  output logic [7:0]     out_url_byte,
  output logic [2:0]     out_method_code,
  output logic [3:0]     out_major_version,
  output logic [3:0]     out_minor_version,
  output logic           out_line_ok,
  output logic           out_last_result
);
  import hrlp_pkg::*;

  cmd_t cur_r;
  logic url_pend_r, sum_pend_r;
  logic busy, taken, done;

  assign busy  = url_pend_r || sum_pend_r;
  assign empty = !busy;
  assign taken = pop && busy;
  assign done  = taken && !(url_pend_r && sum_pend_r);
  assign q_pop = q_nonempty && (!busy || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_pend_r <= 1'b0;
      sum_pend_r <= 1'b0;
    end else if (q_pop) begin
      url_pend_r <= q_head.has_url;
      sum_pend_r <= q_head.has_sum;
    end else if (taken) begin
      if (url_pend_r) begin
        url_pend_r <= 1'b0;
      end else begin
        sum_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_comb begin
    out_kind          = !url_pend_r;
    out_url_byte      = url_pend_r ? cur_r.url_byte : 8'h00;
    out_method_code   = url_pend_r ? 3'd0 : cur_r.method;
    out_major_version = url_pend_r ? 4'd0 : cur_r.major;
    out_minor_version = url_pend_r ? 4'd0 : cur_r.minor;
    out_line_ok       = url_pend_r ? 1'b0 : cur_r.ok;
    out_last_result   = !(url_pend_r && sum_pend_r);
  end

  a_url_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && url_pend_r && sum_pend_r) |=> (sum_pend_r && !url_pend_r))
    else $error("summary lost after URL byte");
  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy || done))
    else $error("command loaded over pending result");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !pop) |=> ($stable(url_pend_r) && $stable(sum_pend_r)))
    else $error("pending result changed while stalled");

endmodule

// ----- src/http_request_line_parser_top.sv -----
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// HTTP request line parser: method, URL bytes, version and status.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while full is low. Each byte is parsed
// in the cycle it is accepted and the results it causes (a URL byte, the line
// summary, or both) go into a command queue of QUEUE_DEPTH entries; the output
// stage drains one result transaction per cycle while pop is high, so a final
// byte that is also a URL byte gives two result transactions. Each result is
// registered in the command queue and then in the output stage.
module http_request_line_parser_top #(
  parameter int QUEUE_DEPTH = hrlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_line_byte,
  input  logic       in_end_of_line,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind,
  output logic [7:0] out_url_byte,
  output logic [2:0] out_method_code,
  output logic [3:0] out_major_version,
  output logic [3:0] out_minor_version,
  output logic       out_line_ok,
  output logic       out_last_result
);
  import hrlp_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_nonempty;

  hrlp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_line_byte  (in_line_byte),
    .in_end_of_line(in_end_of_line),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_cmd)
  );

  hrlp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head_cmd)
  );

  hrlp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nonempty       (q_nonempty),
    .q_head           (head_cmd),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_url_byte     (out_url_byte),
    .out_method_code  (out_method_code),
    .out_major_version(out_major_version),
    .out_minor_version(out_minor_version),
    .out_line_ok      (out_line_ok),
    .out_last_result  (out_last_result)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the HTTP request line parser. Whole request lines, directed
// and random, are fed one byte per transaction with random gaps, and the
// result transactions (URL bytes and line summaries) are checked in order
// against a line parser model. Random receiver stalls, with long holds, back
// the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import hrlp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 580;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 250;

  typedef enum logic [2:0] {
    M_GET, M_POST, M_OPTIONS, M_PUT, M_DELETE, M_CONNECT, M_HEAD, M_TRACE
  } method_e;

  typedef enum logic {K_URL, K_SUMMARY} kind_e;

  typedef struct packed {
    logic [7:0] b;
    logic       eol;
  } line_byte_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] url;
    logic [2:0] method;
    logic [3:0] major;
    logic [3:0] minor;
    logic       ok;
    logic       last;
  } line_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_line_byte = 8'h00;
  logic       in_end_of_line = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_kind;
  logic [7:0] out_url_byte;
  logic [2:0] out_method_code;
  logic [3:0] out_major_version;
  logic [3:0] out_minor_version;
  logic       out_line_ok;
  logic       out_last_result;

  line_byte_t feed_q[$];
  logic [7:0] line_buf[$];
  line_res_t  want_q[$];

  string method_names [8] = '{"GET", "POST", "OPTIONS", "PUT", "DELETE", "CONNECT",
                              "HEAD", "TRACE"};

  // parser state
  logic [3:0] ps = PH_METHOD;
  logic [3:0] mpos = 4'd0;
  logic [7:0] mcand = 8'hff;
  logic [3:0] maj = 4'd0;
  logic [3:0] mnr = 4'd0;
  logic       vok = 1'b0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic rx_hold = 1'b0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  int   in_count = 0;
  int   errors = 0;
  int   cycle_cnt = 0;

  http_request_line_parser_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_line_byte     (in_line_byte),
    .in_end_of_line   (in_end_of_line),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_url_byte     (out_url_byte),
    .out_method_code  (out_method_code),
    .out_major_version(out_major_version),
    .out_minor_version(out_minor_version),
    .out_line_ok      (out_line_ok),
    .out_last_result  (out_last_result)
  );

  always #2 clk = ~clk;

  function automatic logic [3:0] digit_val(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_ZERO + 8'd9) begin
      return 4'(b - CH_ZERO);
    end
    return 4'd0;
  endfunction

  function automatic method_e resolve_method();
    for (int i = 0; i < 8; i++) begin
      if (mcand[i] && method_names[i].len() == int'(mpos)) begin
        return method_e'(i);
      end
    end
    return M_GET;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eol);
    logic      url;
    logic [7:0] keep;
    line_res_t r;
    url  = 1'b0;
    keep = 8'h00;
    case (ps)
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          ps = PH_SKIP1;
        end else begin
          if (mpos < 4'd8) begin
            for (int i = 0; i < 8; i++) begin
              if (int'(mpos) < method_names[i].len() && 8'(method_names[i][mpos]) == b) begin
                keep[i] = 1'b1;
              end
            end
            mpos = mpos + 4'd1;
          end
          mcand = mcand & keep;
        end
      end
      PH_SKIP1, PH_URL: begin
        if (b == CH_SPACE) begin
          if (ps == PH_URL) ps = PH_SKIP2;
        end else begin
          ps  = PH_URL;
          url = 1'b1;
        end
      end
      PH_SKIP2: if (b != CH_SPACE) ps = (b == CH_H) ? PH_T1 : PH_FAIL;
      PH_T1:    ps = (b == CH_T) ? PH_T2 : PH_FAIL;
      PH_T2:    ps = (b == CH_T) ? PH_P : PH_FAIL;
      PH_P:     ps = (b == CH_P) ? PH_SLASH : PH_FAIL;
      PH_SLASH: ps = (b == CH_SLASH) ? PH_MAJOR : PH_FAIL;
      PH_MAJOR: begin
        maj = digit_val(b);
        ps  = PH_DOT;
      end
      PH_DOT: begin
        if (b == CH_DOT) begin
          vok = 1'b1;
          ps  = PH_MINOR;
        end else begin
          ps = PH_FAIL;
        end
      end
      PH_MINOR: begin
        mnr = digit_val(b);
        ps  = PH_DONE;
      end
      default: ;
    endcase
    if (url) begin
      r = '{kind: K_URL, url: b, method: M_GET, major: 4'd0, minor: 4'd0, ok: 1'b0,
            last: !eol};
      want_q.push_back(r);
    end
    if (eol) begin
      r = '{kind: K_SUMMARY, url: 8'h00, method: resolve_method(), major: maj,
            minor: vok ? mnr : 4'd0, ok: vok, last: 1'b1};
      want_q.push_back(r);
      ps    = PH_METHOD;
      mpos  = 4'd0;
      mcand = 8'hff;
      maj   = 4'd0;
      mnr   = 4'd0;
      vok   = 1'b0;
    end
  endtask

  function automatic int check_field(input string name, input logic [7:0] want,
                                     input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  // stimulus construction
  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
  endtask

  task automatic flush_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      feed_q.push_back('{b: line_buf[i], eol: (i == line_buf.size() - 1)});
    end
    line_buf.delete();
  endtask

  function automatic logic [7:0] rand_nonspace();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_digit_or_junk();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic put_spaces();
    int n;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) line_buf.push_back(CH_SPACE);
  endtask

  task automatic gen_line();
    int    mode;
    int    vmode;
    int    n;
    string tag;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : rand_nonspace());
      end
    end else begin
      tag = method_names[$urandom_range(0, 7)];
      case ($urandom_range(0, 7))
        0: begin
          n = $urandom_range(0, 10);
          repeat (n) line_buf.push_back(rand_nonspace());
        end
        1: begin
          put_str(tag);
          line_buf[$urandom_range(0, line_buf.size() - 1)] = rand_nonspace();
        end
        2: begin
          put_str(tag);
          n = $urandom_range(1, 4);
          repeat (n) line_buf.push_back(rand_nonspace());
        end
        default: put_str(tag);
      endcase
      put_spaces();
      n = $urandom_range(1, 5);
      repeat (n) line_buf.push_back(rand_nonspace());
      put_spaces();
      vmode = $urandom_range(0, 9);
      if (vmode == 0) begin
        n = $urandom_range(0, 6);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = line_buf.size();
        put_str("HTTP/");
        if (vmode == 1) line_buf[n + $urandom_range(0, 4)] = 8'($urandom_range(0, 255));
        line_buf.push_back(rand_digit_or_junk());
        line_buf.push_back((vmode == 2) ? 8'($urandom_range(0, 255)) : CH_DOT);
        line_buf.push_back(rand_digit_or_junk());
        if (vmode == 3) begin
          n = $urandom_range(1, 3);
          repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, line_buf.size());
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
    end
    flush_line();
  endtask

  // sender
  always @(negedge clk) begin : drv
    line_byte_t it;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (tx_wait != 0) begin
        tx_wait = tx_wait - 1;
        push <= 1'b0;
      end else if (feed_q.size() != 0) begin
        it = feed_q.pop_front();
        in_line_byte   <= it.b;
        in_end_of_line <= it.eol;
        push           <= 1'b1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_wait = tx_burst ? 0 : $urandom_range(0, 11);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (rx_hold) begin
        pop <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // long receiver holds so the block fills and stalls its input
  initial begin : long_hold
    int thr [2];
    thr = '{150, 550};
    foreach (thr[k]) begin
      while (in_count < thr[k]) @(posedge clk);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // model update and result check
  always @(posedge clk) begin : mon
    line_res_t got;
    line_res_t exp;
    in_taken  <= push && !full;
    out_taken <= pop && !empty;
    if (rst_n) begin
      if (push && !full) begin
        predict_byte(in_line_byte, in_end_of_line);
        in_count <= in_count + 1;
      end
      if (pop && !empty) begin
        got = '{kind: out_kind, url: out_url_byte, method: out_method_code,
                major: out_major_version, minor: out_minor_version, ok: out_line_ok,
                last: out_last_result};
        if (want_q.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp = want_q.pop_front();
          errors += check_field("out_kind", 8'(exp.kind), 8'(got.kind));
          errors += check_field("out_url_byte", exp.url, got.url);
          errors += check_field("out_method_code", 8'(exp.method), 8'(got.method));
          errors += check_field("out_major_version", 8'(exp.major), 8'(got.major));
          errors += check_field("out_minor_version", 8'(exp.minor), 8'(got.minor));
          errors += check_field("out_line_ok", 8'(exp.ok), 8'(got.ok));
          errors += check_field("out_last_result", 8'(exp.last), 8'(got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stim
    int dir_bytes;
    put_str("GET /a HTTP/1.1");                flush_line();
    put_str("POST /b HTTP/2.0");               flush_line();
    put_str("OPTIONS * HTTP/9.9");             flush_line();
    put_str("PUT  x  HTTP/1.x");               flush_line();
    put_str("DELETE /");
    line_buf.push_back(8'hff);
    put_str(" HTTP/a.1");                      flush_line();
    put_str("CONNECT h:1 HTT");                flush_line();
    put_str("HEAD / HTTP/1");                  flush_line();
    put_str("TRACE / HTTP/1.");                flush_line();
    put_str("TRACEX / HTTP/1.1");              flush_line();
    put_str("GETTINGS / HTTP/1.0 tail");       flush_line();
    put_str("G");
    line_buf.push_back(8'h00);
    put_str("T / HTTP/1.1");                   flush_line();
    put_str("GET /z HXTP/1.1 zz");             flush_line();
    put_str("DEL /q");                         flush_line();
    put_str("GET /x HTTP/1.2X");               flush_line();
    put_str(" ");                              flush_line();
    line_buf.push_back(8'h00);                 flush_line();
    dir_bytes = feed_q.size();
    while (feed_q.size() < dir_bytes + RANDOM_BYTES) gen_line();

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || push) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
